FILE: hdl/shacb_pkg.sv
package shacb_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic valid;
      logic restart;
   } q_item_type;

   localparam logic [1:0] CSR_SEED  = 2'd0;
   localparam logic [1:0] CSR_COUNT = 2'd1;
   localparam logic [1:0] CSR_MIX   = 2'd2;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   localparam word_type KINIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type KROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type swap32(word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: hdl/shacb_front.sv
module shacb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] restart
   output shacb_pkg::q_item_type q_item,
   input  logic                  q_pop
);

   logic [1:0] cnt_ff, cnt_in;
   logic       slot0_ff, slot1_ff;
   logic       push;

   assign req_tready     = (cnt_ff != 2'd2);
   assign push           = req_tvalid && req_tready;
   assign q_item.valid   = (cnt_ff != 2'd0);
   assign q_item.restart = slot0_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && q_pop) begin
         if (cnt_ff == 2'd1) begin
            slot0_ff <= req_tdata[0];
         end else begin
            slot0_ff <= slot1_ff;
            slot1_ff <= req_tdata[0];
         end
      end else if (q_pop) begin
         slot0_ff <= slot1_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            slot0_ff <= req_tdata[0];
         end else begin
            slot1_ff <= req_tdata[0];
         end
      end
   end

endmodule

FILE: hdl/shacb_core.sv
module shacb_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  shacb_pkg::word_type msg_hi,
   input  shacb_pkg::word_type msg_lo,
   output logic                done,
   output shacb_pkg::word_type digest [8]
);

   shacb_pkg::word_type s_ff [8];
   shacb_pkg::word_type w_ff [16];
   logic [5:0]          rnd_ff;
   logic                busy_ff, done_ff;
   shacb_pkg::word_type e1, ch, t1, e0, mj, t2, s0w, s1w, w_in;

   always_comb begin
      e1  = shacb_pkg::rotr(s_ff[4], 6) ^ shacb_pkg::rotr(s_ff[4], 11)
            ^ shacb_pkg::rotr(s_ff[4], 25);
      ch  = (s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]);
      t1  = s_ff[7] + e1 + ch + shacb_pkg::KROUND[rnd_ff] + w_ff[0];
      e0  = shacb_pkg::rotr(s_ff[0], 2) ^ shacb_pkg::rotr(s_ff[0], 13)
            ^ shacb_pkg::rotr(s_ff[0], 22);
      mj  = (s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]);
      t2  = e0 + mj;
      s0w = shacb_pkg::rotr(w_ff[1], 7) ^ shacb_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = shacb_pkg::rotr(w_ff[14], 17) ^ shacb_pkg::rotr(w_ff[14], 19)
            ^ (w_ff[14] >> 10);
      w_in = w_ff[0] + s0w + w_ff[9] + s1w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (rnd_ff == 6'd63);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (rnd_ff == 6'd63)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         s_ff   <= shacb_pkg::KINIT;
         rnd_ff <= 6'd0;
         for (int i = 3; i < 15; i++) begin
            w_ff[i] <= '0;
         end
         w_ff[0]  <= msg_hi;
         w_ff[1]  <= msg_lo;
         w_ff[2]  <= 32'h80000000;
         w_ff[15] <= 32'd64;
      end else if (busy_ff) begin
         s_ff[7] <= s_ff[6];
         s_ff[6] <= s_ff[5];
         s_ff[5] <= s_ff[4];
         s_ff[4] <= s_ff[3] + t1;
         s_ff[3] <= s_ff[2];
         s_ff[2] <= s_ff[1];
         s_ff[1] <= s_ff[0];
         s_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_in;
         rnd_ff   <= rnd_ff + 6'd1;
      end
   end

   assign done = done_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[i] = shacb_pkg::swap32(s_ff[i] + shacb_pkg::KINIT[i]);
      end
   end

endmodule

FILE: hdl/shacb_back.sv
module shacb_back #(
   parameter int MAX_VALUES = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  shacb_pkg::q_item_type q_item,
   output logic                  q_pop,
   input  logic [63:0]           seed_value,
   input  logic [9:0]            value_count,
   input  logic [16:0]           cross_mix,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HASH = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;
   localparam logic [16:0] MAX_V  = 17'(MAX_VALUES);

   logic [1:0]          state_ff;
   logic [2:0]          pos_ff;
   logic [9:0]          idx_ff;
   logic                started_ff, adv_ff, reseed_ff;
   logic                rsp_valid_ff, rsp_last_ff;
   logic [31:0]         rsp_data_ff;
   logic [48:0]         prod_a_ff, prod_b_ff, sum;
   shacb_pkg::word_type dig_a_ff [8];
   shacb_pkg::word_type dig_b_ff [8];
   shacb_pkg::word_type new_a [8];
   shacb_pkg::word_type new_b [8];
   shacb_pkg::word_type hi_a, lo_a, hi_b, lo_b;
   logic                reseed, start, done_a, done_b, out_fire, is_last;
   logic [16:0]         cnt, c, cm;

   assign reseed = q_item.restart || !started_ff;
   assign q_pop  = (state_ff == ST_IDLE) && q_item.valid;
   assign start  = q_pop && (reseed || adv_ff);

   assign hi_a = reseed ? shacb_pkg::swap32(seed_value[31:0])
                        : shacb_pkg::swap32(dig_a_ff[0]);
   assign lo_a = reseed ? shacb_pkg::swap32(seed_value[63:32])
                        : shacb_pkg::swap32(dig_a_ff[1]);
   assign hi_b = reseed ? shacb_pkg::swap32(~seed_value[31:0])
                        : shacb_pkg::swap32(dig_b_ff[0]);
   assign lo_b = reseed ? shacb_pkg::swap32(~seed_value[63:32])
                        : shacb_pkg::swap32(dig_b_ff[1]);

   shacb_core u_core_a (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .msg_hi (hi_a),
      .msg_lo (lo_a),
      .done   (done_a),
      .digest (new_a)
   );

   shacb_core u_core_b (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .msg_hi (hi_b),
      .msg_lo (lo_b),
      .done   (done_b),
      .digest (new_b)
   );

   always_comb begin
      if (value_count == 10'd0) begin
         cnt = 17'd1;
      end else if ({7'd0, value_count} > MAX_V) begin
         cnt = MAX_V;
      end else begin
         cnt = {7'd0, value_count};
      end
      c  = (cross_mix > shacb_pkg::WEIGHT_ONE) ? shacb_pkg::WEIGHT_ONE : cross_mix;
      cm = shacb_pkg::WEIGHT_ONE - c;
   end

   assign is_last  = ({7'd0, idx_ff} + 17'd1) >= cnt;
   assign out_fire = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign sum      = prod_a_ff + prod_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 3'd0;
         idx_ff       <= 10'd0;
         started_ff   <= 1'b0;
         adv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  state_ff <= (reseed || adv_ff) ? ST_HASH : ST_MUL;
               end
            end
            ST_HASH: begin
               if (done_a && done_b) begin
                  state_ff <= ST_MUL;
                  adv_ff   <= 1'b0;
                  if (reseed_ff) begin
                     pos_ff     <= 3'd0;
                     idx_ff     <= 10'd0;
                     started_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_fire) begin
                  state_ff     <= ST_IDLE;
                  pos_ff       <= pos_ff + 3'd1;
                  if (is_last) begin
                     started_ff <= 1'b0;
                     idx_ff     <= 10'd0;
                     adv_ff     <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + 10'd1;
                     adv_ff <= (pos_ff == 3'd7);
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         reseed_ff <= reseed;
      end
      if ((state_ff == ST_HASH) && done_a && done_b) begin
         dig_a_ff <= new_a;
         dig_b_ff <= new_b;
      end
      if (state_ff == ST_MUL) begin
         prod_a_ff <= dig_a_ff[pos_ff] * cm;
         prod_b_ff <= dig_b_ff[pos_ff] * c;
      end
      if (out_fire) begin
         rsp_data_ff <= sum[47:16];
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/sha256_chain_random_blend.sv
// channel | dir | payload
// req     | in  | tdata[0] restart
// rsp     | out | tdata[31:0] random_word, tlast last
// csr     | in  | csr_index register, csr_data value
// An item that reloads or steps the chains runs both SHA-256 cores side by
// side before the blend; other items go straight to the blend.
// Reset is synchronous and clears control state; digests load on first use.
// A two-entry queue lets requests land while the back end hashes or the
// result register waits on rsp_tready.
module sha256_chain_random_blend #(
   parameter int MAX_VALUES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] random_word
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0]           seed_ff;
   logic [9:0]            count_ff;
   logic [16:0]           mix_ff;
   shacb_pkg::q_item_type q_item;
   logic                  q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 64'd0;
         count_ff <= 10'd1;
         mix_ff   <= 17'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            shacb_pkg::CSR_SEED:  seed_ff  <= csr_data;
            shacb_pkg::CSR_COUNT: count_ff <= csr_data[9:0];
            shacb_pkg::CSR_MIX:   mix_ff   <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   shacb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   shacb_back #(
      .MAX_VALUES (MAX_VALUES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .seed_value  (seed_ff),
      .value_count (count_ff),
      .cross_mix   (mix_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTH
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_item.valid) else $error("pop from empty queue");
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result valid after reset");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] CSR_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } blend_type;

   typedef struct {
      logic        is_csr;
      logic [1:0]  index;
      logic [63:0] data;
      logic [7:0]  req;
   } job_type;

   sha256_chain_random_blend dut (.*);

   job_type   pending_jobs[$];
   blend_type expected_words[$];
   logic      fail_seen;
   int        cycle_count;
   int        idle_pct;

   // predictor state
   logic [63:0]         p_seed;
   logic [9:0]          p_count;
   logic [16:0]         p_mix;
   shacb_pkg::word_type p_dig_a[8];
   shacb_pkg::word_type p_dig_b[8];
   logic [2:0]          p_pos;
   int                  p_index;
   logic                p_started;

   function automatic void sha8(shacb_pkg::word_type hi, shacb_pkg::word_type lo,
                                output shacb_pkg::word_type dst[8]);
      shacb_pkg::word_type w[64];
      shacb_pkg::word_type s[8];
      shacb_pkg::word_type s0, s1, e1, ch, t1, e0, mj;
      for (int i = 0; i < 64; i++) w[i] = '0;
      w[0] = hi;
      w[1] = lo;
      w[2] = 32'h80000000;
      w[15] = 32'd64;
      for (int i = 16; i < 64; i++) begin
         s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]}
            ^ (w[i-15] >> 3);
         s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]}
            ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) s[i] = shacb_pkg::KINIT[i];
      for (int i = 0; i < 64; i++) begin
         e1 = {s[4][5:0], s[4][31:6]} ^ {s[4][10:0], s[4][31:11]}
            ^ {s[4][24:0], s[4][31:25]};
         ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
         t1 = s[7] + e1 + ch + shacb_pkg::KROUND[i] + w[i];
         e0 = {s[0][1:0], s[0][31:2]} ^ {s[0][12:0], s[0][31:13]}
            ^ {s[0][21:0], s[0][31:22]};
         mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
         s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
         s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + e0 + mj;
      end
      for (int i = 0; i < 8; i++) begin
         t1 = s[i] + shacb_pkg::KINIT[i];
         dst[i] = {t1[7:0], t1[15:8], t1[23:16], t1[31:24]};
      end
   endfunction

   function automatic shacb_pkg::word_type bswap(shacb_pkg::word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic void write_reg(logic [1:0] idx, logic [63:0] val);
      if (idx == shacb_pkg::CSR_SEED) p_seed = val;
      else if (idx == shacb_pkg::CSR_COUNT) p_count = val[9:0];
      else if (idx == shacb_pkg::CSR_MIX) p_mix = val[16:0];
   endfunction

   function automatic blend_type next_blend(logic restart);
      blend_type r;
      int cnt;
      logic [63:0] nseed;
      logic [16:0] c;
      logic [63:0] sum;
      cnt = int'(p_count);
      if (cnt < 1) cnt = 1;
      if (cnt > 512) cnt = 512;
      c = (p_mix > shacb_pkg::WEIGHT_ONE) ? shacb_pkg::WEIGHT_ONE : p_mix;
      if (restart || !p_started) begin
         nseed = ~p_seed;
         sha8(bswap(p_seed[31:0]), bswap(p_seed[63:32]), p_dig_a);
         sha8(bswap(nseed[31:0]), bswap(nseed[63:32]), p_dig_b);
         p_pos = 3'd0;
         p_index = 0;
         p_started = 1'b1;
      end
      sum = 64'(p_dig_a[p_pos]) * 64'(shacb_pkg::WEIGHT_ONE - c)
            + 64'(p_dig_b[p_pos]) * 64'(c);
      r.word = sum[47:16];
      r.last = (p_index + 1 >= cnt);
      p_pos = p_pos + 3'd1;
      if (p_pos == 3'd0) begin
         sha8(bswap(p_dig_a[0]), bswap(p_dig_a[1]), p_dig_a);
         sha8(bswap(p_dig_b[0]), bswap(p_dig_b[1]), p_dig_b);
      end
      p_index++;
      if (r.last) begin
         p_started = 1'b0;
         p_index = 0;
      end
      return r;
   endfunction

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // driver: csr writes only go out once the block has drained
   int   drain_cnt;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
         drain_cnt  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_words.insert(expected_words.size(), next_blend(req_tdata[0]));
            void'(pending_jobs.pop_front());
         end
         if (csr_valid && csr_ready) begin
            write_reg(csr_index, csr_data);
            void'(pending_jobs.pop_front());
         end
         drain_cnt <= (expected_words.size() == 0 && !req_tvalid) ? drain_cnt + 1 : 0;
         if ((req_tvalid && !req_tready) || (csr_valid && !csr_ready)) begin
         end else if (pending_jobs.size() == 0 || (req_tvalid && req_tready
                      && pending_jobs.size() == 0)) begin
            req_tvalid <= 1'b0;
            csr_valid  <= 1'b0;
         end else if (pending_jobs[0].is_csr) begin
            req_tvalid <= 1'b0;
            if (!csr_valid && !req_tvalid && expected_words.size() == 0
                && drain_cnt > 100) begin
               csr_valid <= 1'b1;
               csr_index <= pending_jobs[0].index;
               csr_data  <= pending_jobs[0].data;
            end else begin
               csr_valid <= 1'b0;
            end
         end else begin
            csr_valid <= 1'b0;
            if ($urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_jobs[0].req;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word %h", rsp_tdata);
               fail_seen = 1'b1;
            end else begin
               if (rsp_tdata !== expected_words[0].word) begin
                  $error("random_word expected %h actual %h",
                         expected_words[0].word, rsp_tdata);
                  fail_seen = 1'b1;
               end
               if (rsp_tlast !== expected_words[0].last) begin
                  $error("last expected %b actual %b", expected_words[0].last, rsp_tlast);
                  fail_seen = 1'b1;
               end
               void'(expected_words.pop_front());
            end
         end
         if (cycle_count > 600000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic void add_csr(logic [1:0] idx, logic [63:0] val);
      job_type j;
      j.is_csr = 1'b1; j.index = idx; j.data = val; j.req = '0;
      pending_jobs.insert(pending_jobs.size(), j);
   endfunction

   function automatic void add_req(logic restart, logic [6:0] junk);
      job_type j;
      j.is_csr = 1'b0; j.index = '0; j.data = '0; j.req = {junk, restart};
      pending_jobs.insert(pending_jobs.size(), j);
   endfunction

   initial begin
      logic [16:0] mixes[5];
      reset = 1'b1;
      req_tdata = '0;
      csr_index = '0;
      csr_data = '0;
      fail_seen = 1'b0;
      cycle_count = 0;
      idle_pct = 0;
      p_seed = '0; p_count = 10'd1; p_mix = '0;
      p_pos = 3'd0; p_index = 0; p_started = 1'b0;
      for (int i = 0; i < 8; i++) begin
         p_dig_a[i] = '0; p_dig_b[i] = '0;
      end
      mixes = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd1};
      // directed: reset defaults, then extremes
      add_req(1'b0, 7'd0);
      add_req(1'b1, 7'h7f);
      add_csr(shacb_pkg::CSR_COUNT, 64'd0);
      add_req(1'b0, 7'd0);
      add_csr(shacb_pkg::CSR_SEED, 64'hffff_ffff_ffff_ffff);
      add_csr(shacb_pkg::CSR_COUNT, 64'd1023);
      add_csr(shacb_pkg::CSR_MIX, 64'h1ffff);
      for (int i = 0; i < 10; i++) add_req(i == 9, 7'(i));
      add_csr(shacb_pkg::CSR_MIX, 64'd65536);
      add_csr(shacb_pkg::CSR_COUNT, 64'd5);
      add_csr(CSR_NONE, 64'h1234);
      for (int i = 0; i < 7; i++) add_req(1'b0, 7'd0);
      add_csr(shacb_pkg::CSR_COUNT, 64'd2);
      add_req(1'b0, 7'd0);
      add_csr(shacb_pkg::CSR_COUNT, 64'd512);
      add_csr(shacb_pkg::CSR_MIX, 64'd0);
      // random phases
      for (int ph = 0; ph < 14; ph++) begin
         add_csr(shacb_pkg::CSR_SEED, {$urandom, $urandom});
         add_csr(shacb_pkg::CSR_COUNT,
                 (ph % 5 == 0) ? 64'd512 : 64'($urandom_range(40, 0)));
         add_csr(shacb_pkg::CSR_MIX,
                 (ph < 5) ? 64'(mixes[ph]) : 64'($urandom_range(131071)));
         if ($urandom_range(3) == 0) add_csr(CSR_NONE, {$urandom, $urandom});
         for (int i = 0; i < 120; i++)
            add_req($urandom_range(29) == 0, 7'($urandom));
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_jobs.size() != 0 || expected_words.size() != 0) begin
         @(posedge clock);
         idle_pct <= (cycle_count % 20000 < 4000) ? 0 : 38;
      end
      repeat (200) @(posedge clock);
      if (!fail_seen && expected_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
